// ===== design/spb_pkg.sv =====
// shared types, constants and helpers for the sorted palette builder
package spb_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int COLOR_W       = 24;
  localparam int CH_W          = 8;
  localparam int IDX_OUT_W     = 8;
  localparam int CNT_OUT_W     = 9;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 24;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // operation codes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_MAP   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT_COL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BGR_ORDER       = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // status from the search unit to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } srch_stat_t;

  function automatic rgb_t split_color(input logic [COLOR_W-1:0] c, input logic bgr);
    rgb_t res;
    res.green = c[15:8];
    if (bgr) begin
      res.red  = c[7:0];
      res.blue = c[23:16];
    end else begin
      res.red  = c[23:16];
      res.blue = c[7:0];
    end
    return res;
  endfunction

endpackage

// ===== design/spb_if.sv =====
// request and result channel interfaces
interface spb_in_if import spb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic [COLOR_W-1:0]   pixel_color;
  logic [7:0]           entry_select;

  modport source (output valid, operation, pixel_color, entry_select, input ready);
  modport sink   (input valid, operation, pixel_color, entry_select, output ready);
endinterface

interface spb_out_if import spb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [IDX_OUT_W-1:0] palette_index;
  logic                 palette_ok;
  logic [CNT_OUT_W-1:0] color_count;
  logic [CH_W-1:0]      red_out;
  logic [CH_W-1:0]      green_out;
  logic [CH_W-1:0]      blue_out;
  logic [CH_W-1:0]      alpha_out;

  modport source (output valid, found, palette_index, palette_ok, color_count,
                  red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, found, palette_index, palette_ok, color_count,
                  red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ===== design/spb_ram.sv =====
// generic single write port ram with registered read
module spb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/spb_search.sv =====
// binary search unit: each probe passes an issue state and a compare state through the ram read port
module spb_search import spb_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [COLOR_W-1:0]                 key,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   count,
  input  logic [COLOR_W-1:0]                 rd_data,
  output logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   pos,
  output srch_stat_t                         stat
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_CMP} state_t;

  state_t             state;
  logic [COLOR_W-1:0] key_reg;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [AW-1:0]      mid;
  logic [CW:0]        span_sum;
  logic               key_lt;
  logic               key_eq;
  logic               done;
  logic               found;

  // shared comparator
  assign key_lt = key_reg < rd_data;
  assign key_eq = key_reg == rd_data;

  assign span_sum = {1'b0, lo} + {1'b0, hi};
  assign rd_addr  = AW'(span_sum >> 1);

  assign stat.busy  = (state != S_IDLE);
  assign stat.done  = done;
  assign stat.found = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key_reg <= key;
            lo      <= '0;
            hi      <= count;
            state   <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (lo < hi) begin
            mid   <= rd_addr;
            state <= S_CMP;
          end else begin
            done  <= 1'b1;
            found <= 1'b0;
            pos   <= lo;
            state <= S_IDLE;
          end
        end
        S_CMP: begin
          if (key_eq) begin
            done  <= 1'b1;
            found <= 1'b1;
            pos   <= CW'(mid);
            state <= S_IDLE;
          end else begin
            if (key_lt) begin
              hi <= CW'(mid);
            end else begin
              lo <= CW'(mid) + 1'b1;
            end
            state <= S_ISSUE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (lo <= hi))
    else $error("search bounds crossed");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ((CW'(mid) >= lo) && (CW'(mid) < hi)))
    else $error("probe outside search window");

  a_hit_from_compare: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> $past(state == S_CMP))
    else $error("hit reported without a compare");
`endif

endmodule

// ===== design/sorted_palette_builder.sv =====
// sorted palette builder top level: sequencer, table ram and search unit
//
//  channel   dir   handshake           payload
//  in_req    in    valid / ready       operation, pixel_color, entry_select
//  out_res   out   valid / ready       found, palette_index, palette_ok, color_count,
//                                      red_out, green_out, blue_out, alpha_out
//  cfg       in    cfg_we (no wait)    cfg_index, cfg_data
//
//  one request at a time; the table sits in a single ram with one read and one write port
//  clear and add on an invalid palette go straight to finish; read passes a read state first
//  add and map run a binary search, each probe an issue state and a compare state,
//  p <= ceil(log2(n+1)) probes of the ram for n entries
//  an insert shifts entries pos..n-1 up one slot through read and write states, then writes the colour
//  rst is synchronous; no clearing pass, data of entries beyond the count is never used
//  a new request is taken while a result waits; the next result then holds until taken
module sorted_palette_builder import spb_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  spb_in_if.sink                in_req,
  spb_out_if.source             out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_SHIFT_RD, ST_SHIFT_WR, ST_READ, ST_FINISH
  } state_t;

  // configuration
  logic               tr_en;
  logic [COLOR_W-1:0] tr_col;
  logic               bgr;

  // sequencer state
  state_t             state;
  op_t                op_reg;
  op_t                in_op;
  logic [COLOR_W-1:0] col_reg;
  logic [7:0]         sel_reg;
  logic [CW-1:0]      count;
  logic               table_valid;
  logic [CW-1:0]      r;          // slot being filled during the shift
  logic [CW-1:0]      ins_pos;
  logic               accept;

  // held result
  logic               res_found;
  logic [CW-1:0]      res_pos;
  rgb_t               res_rgb;
  logic [CH_W-1:0]    res_alpha;

  // output register
  logic                 out_valid;
  logic                 o_found;
  logic [IDX_OUT_W-1:0] o_index;
  logic                 o_ok;
  logic [CNT_OUT_W-1:0] o_count;
  rgb_t                 o_rgb;
  logic [CH_W-1:0]      o_alpha;

  // ram ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COLOR_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;

  // search unit
  logic               srch_start;
  logic [AW-1:0]      srch_addr;
  logic [CW-1:0]      srch_pos;
  srch_stat_t         srch_stat;

  // read range check
  logic               sel_in_range;
  rgb_t               rd_rgb;

  assign in_op  = op_t'(in_req.operation);
  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state == ST_IDLE);

  // map always searches, add only while the palette is still valid
  assign srch_start = accept && ((in_op == OP_MAP) || ((in_op == OP_ADD) && table_valid));

  assign sel_in_range = ({{CW{1'b0}}, sel_reg} < {8'd0, count}) &&
                        ({{CW{1'b0}}, sel_reg} < (CW + 8)'(TABLE_DEPTH));
  assign rd_rgb = split_color(ram_rdata, bgr);

  assign out_res.valid         = out_valid;
  assign out_res.found         = o_found;
  assign out_res.palette_index = o_index;
  assign out_res.palette_ok    = o_ok;
  assign out_res.color_count   = o_count;
  assign out_res.red_out       = o_rgb.red;
  assign out_res.green_out     = o_rgb.green;
  assign out_res.blue_out      = o_rgb.blue;
  assign out_res.alpha_out     = o_alpha;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tr_en  <= 1'b0;
      tr_col <= '0;
      bgr    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRANSPARENT_EN:  tr_en  <= cfg_data[0];
        CFG_TRANSPARENT_COL: tr_col <= cfg_data[COLOR_W-1:0];
        CFG_BGR_ORDER:       bgr    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ram port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = tr_col;
    ram_raddr = srch_addr;
    unique case (state)
      ST_IDLE: begin
        // clear preloads the transparent colour at slot zero when transparency is enabled
        ram_we    = accept && (in_op == OP_CLEAR) && tr_en;
        ram_raddr = AW'(in_req.entry_select);
      end
      ST_SHIFT_RD: begin
        if (r > ins_pos) begin
          ram_raddr = AW'(r - 1'b1);
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(ins_pos);
          ram_wdata = col_reg;
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(r);
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      table_valid <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      // finish reloads the register itself when the old result leaves
      if (out_valid && out_res.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_reg    <= in_op;
            col_reg   <= in_req.pixel_color;
            sel_reg   <= in_req.entry_select;
            res_found <= 1'b0;
            res_pos   <= '0;
            res_rgb   <= '0;
            res_alpha <= '0;
            unique case (in_op)
              OP_CLEAR: begin
                count       <= tr_en ? CW'(1) : '0;
                table_valid <= 1'b1;
                state       <= ST_FINISH;
              end
              OP_ADD: begin
                state <= table_valid ? ST_SEARCH : ST_FINISH;
              end
              OP_MAP: begin
                state <= ST_SEARCH;
              end
              OP_READ: begin
                state <= ST_READ;
              end
            endcase
          end
        end
        ST_SEARCH: begin
          if (srch_stat.done) begin
            if (op_reg == OP_MAP) begin
              res_found <= srch_stat.found;
              res_pos   <= srch_stat.found ? srch_pos : '0;
              res_rgb   <= split_color(col_reg, bgr);
              state     <= ST_FINISH;
            end else if (srch_stat.found) begin
              res_found <= 1'b1;
              res_pos   <= srch_pos;
              state     <= ST_FINISH;
            end else if (count >= CW'(TABLE_DEPTH)) begin
              // new colour at a full table
              table_valid <= 1'b0;
              state       <= ST_FINISH;
            end else begin
              r       <= count;
              ins_pos <= srch_pos;
              state   <= ST_SHIFT_RD;
            end
          end
        end
        ST_SHIFT_RD: begin
          if (r > ins_pos) begin
            state <= ST_SHIFT_WR;
          end else begin
            // new colour written this cycle
            count   <= count + 1'b1;
            res_pos <= ins_pos;
            state   <= ST_FINISH;
          end
        end
        ST_SHIFT_WR: begin
          r     <= r - 1'b1;
          state <= ST_SHIFT_RD;
        end
        ST_READ: begin
          res_pos <= CW'(sel_reg);
          if (sel_in_range) begin
            res_found <= 1'b1;
            res_rgb   <= rd_rgb;
            res_alpha <= (tr_en && (ram_rdata == tr_col)) ? '0 : ALPHA_OPAQUE;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || out_res.ready) begin
            out_valid <= 1'b1;
            o_found   <= res_found;
            o_index   <= IDX_OUT_W'(res_pos);
            o_ok      <= table_valid;
            o_count   <= CNT_OUT_W'(count);
            o_rgb     <= res_rgb;
            o_alpha   <= res_alpha;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  spb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spb_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (srch_start),
    .key     (in_req.pixel_color),
    .count   (count),
    .rd_data (ram_rdata),
    .rd_addr (srch_addr),
    .pos     (srch_pos),
    .stat    (srch_stat)
  );

`ifndef NO_ASSERTIONS
  a_busy_search_blocks: assert property (@(posedge clk) disable iff (rst)
    srch_stat.busy |-> !in_req.ready)
    else $error("request taken while search runs");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SHIFT_RD) && !(r > ins_pos)) |=> (count == $past(count) + 1'b1))
    else $error("insert did not bump the count");

  a_invalid_only_full: assert property (@(posedge clk) disable iff (rst)
    $fell(table_valid) |-> ($past(count) == CW'(TABLE_DEPTH)))
    else $error("palette invalidated below full");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside finish");
`endif

endmodule
